[rtl/helical_field_projection_core_assert.svh]
// Assertion macros used by the helical field projection top level.
`ifndef HELICAL_FIELD_PROJECTION_CORE_ASSERT_SVH
`define HELICAL_FIELD_PROJECTION_CORE_ASSERT_SVH
`ifndef SYNTH
`define HFP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hfp check failed");
`define HFP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hfp check failed");
`else
`define HFP_ASSERT_IMP(label, clk, rstn, ante, cons)
`define HFP_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

[rtl/hfp_pkg.sv]
// Types, constants and helpers of the helical field projection block.
`timescale 1ns / 1ps
package hfp_pkg;

    localparam int DATA_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int UNIT_FRAC  = 30;
    localparam int NORM_BITS  = 31;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;
    localparam int UV_LAT     = 4 + SQRT_STEPS + 1 + DIV_STEPS + 1;
    localparam int MIX_LAT    = 4;

    typedef logic signed [DATA_BITS-1:0] word_t;
    typedef word_t [2:0] vec3_t;

    localparam word_t ONE_Q = word_t'(64'd1 << FRAC_BITS);

    typedef struct packed {
        word_t wave_x;
        word_t wave_y;
        word_t wave_z;
        word_t fx_real;
        word_t fx_imag;
        word_t fy_real;
        word_t fy_imag;
        word_t fz_real;
        word_t fz_imag;
        logic  grid_end;
    } in_word_t;

    typedef struct packed {
        word_t hx_real;
        word_t hx_imag;
        word_t hy_real;
        word_t hy_imag;
        word_t hz_real;
        word_t hz_imag;
        logic  grid_end_out;
    } out_word_t;

    typedef struct packed {
        word_t fx_real;
        word_t fx_imag;
        word_t fy_real;
        word_t fy_imag;
        word_t fz_real;
        word_t fz_imag;
        logic  grid_end;
    } side_t;

    typedef struct packed {
        vec3_t unit;
        word_t norm;
        word_t alpha_norm;
        logic  nonzero;
        side_t side;
    } mix_in_t;

    function automatic logic [5:0] lead_zeros(input logic [31:0] x);
        logic [5:0] n;
        logic       found;
        n     = 6'd32;
        found = 1'b0;
        for (int i = 31; i >= 0; i--) begin
            if (!found && x[i]) begin
                n     = 6'(31 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

[rtl/hfp_unit_vec.sv]
// Pipelined unit vector: normalize, sum of squares, square root, three dividers.
`timescale 1ns / 1ps
module hfp_unit_vec (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  hfp_pkg::vec3_t vec_in,
    output logic          out_valid,
    output hfp_pkg::vec3_t unit_out,
    output logic          nonzero_out
);
    localparam int SQ = hfp_pkg::SQRT_STEPS;
    localparam int DV = hfp_pkg::DIV_STEPS;
    localparam int UF = hfp_pkg::UNIT_FRAC;

    // Stage 1: magnitudes and signs.
    logic [2:0][31:0] mag1_reg;
    logic [2:0]       neg1_reg;
    logic             v1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                neg1_reg[i] <= vec_in[i][31];
                mag1_reg[i] <= vec_in[i][31] ? 32'(-vec_in[i]) : 32'(vec_in[i]);
            end
        end
    end

    // Stage 2: shift all magnitudes so the largest lies in [2^30, 2^31).
    logic [31:0]      mx;
    logic [5:0]       lz;
    logic [2:0][30:0] nmag2_next;
    logic [2:0][30:0] nmag2_reg;
    logic [2:0]       neg2_reg;
    logic             nz2_reg;
    logic             v2_reg;

    always_comb begin
        mx = mag1_reg[0];
        if (mag1_reg[1] > mx) begin
            mx = mag1_reg[1];
        end
        if (mag1_reg[2] > mx) begin
            mx = mag1_reg[2];
        end
        lz = hfp_pkg::lead_zeros(mx);
        for (int i = 0; i < 3; i++) begin
            if (lz == 6'd0) begin
                nmag2_next[i] = mag1_reg[i][31:1];
            end else begin
                nmag2_next[i] = 31'(mag1_reg[i] << (lz - 6'd1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nmag2_reg <= nmag2_next;
            neg2_reg  <= neg1_reg;
            nz2_reg   <= (mx != 32'd0);
        end
    end

    // Stage 3: squares. Stage 4: their sum.
    logic [2:0][61:0] sq3_reg;
    logic [2:0][30:0] nmag3_reg;
    logic [2:0]       neg3_reg;
    logic             nz3_reg;
    logic             v3_reg;
    logic [63:0]      sum4_reg;
    logic [2:0][30:0] nmag4_reg;
    logic [2:0]       neg4_reg;
    logic             nz4_reg;
    logic             v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq3_reg[i] <= 62'(nmag2_reg[i]) * 62'(nmag2_reg[i]);
            end
            nmag3_reg <= nmag2_reg;
            neg3_reg  <= neg2_reg;
            nz3_reg   <= nz2_reg;
            sum4_reg  <= 64'(sq3_reg[0]) + 64'(sq3_reg[1]) + 64'(sq3_reg[2]);
            nmag4_reg <= nmag3_reg;
            neg4_reg  <= neg3_reg;
            nz4_reg   <= nz3_reg;
        end
    end

    // Square root, one result bit per stage.
    logic [63:0]      rad_reg  [SQ];
    logic [63:0]      root_reg [SQ];
    logic [2:0][30:0] sm_reg   [SQ];
    logic [2:0]       sneg_reg [SQ];
    logic             snz_reg  [SQ];
    logic             sv_reg   [SQ];

    for (genvar s = 0; s < SQ; s++) begin : g_sqrt
        localparam logic [63:0] BITV = 64'd1 << (62 - 2 * s);
        logic [63:0]      rad_in;
        logic [63:0]      root_in;
        logic [63:0]      trial;
        logic [2:0][30:0] m_in;
        logic [2:0]       neg_in;
        logic             nz_in;
        logic             v_in;

        if (s == 0) begin : g_first
            assign rad_in  = sum4_reg;
            assign root_in = 64'd0;
            assign m_in    = nmag4_reg;
            assign neg_in  = neg4_reg;
            assign nz_in   = nz4_reg;
            assign v_in    = v4_reg;
        end else begin : g_next
            assign rad_in  = rad_reg[s-1];
            assign root_in = root_reg[s-1];
            assign m_in    = sm_reg[s-1];
            assign neg_in  = sneg_reg[s-1];
            assign nz_in   = snz_reg[s-1];
            assign v_in    = sv_reg[s-1];
        end

        assign trial = root_in + BITV;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sv_reg[s] <= 1'b0;
            end else if (en) begin
                sv_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (rad_in >= trial) begin
                    rad_reg[s]  <= rad_in - trial;
                    root_reg[s] <= (root_in >> 1) + BITV;
                end else begin
                    rad_reg[s]  <= rad_in;
                    root_reg[s] <= root_in >> 1;
                end
                sm_reg[s]   <= m_in;
                sneg_reg[s] <= neg_in;
                snz_reg[s]  <= nz_in;
            end
        end
    end

    // Numerators with half the divisor added for rounding.
    logic [31:0]      root_m;
    logic [2:0][61:0] num5_reg;
    logic [31:0]      m5_reg;
    logic [2:0]       neg5_reg;
    logic             nz5_reg;
    logic             v5_reg;

    assign root_m = root_reg[SQ-1][31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= sv_reg[SQ-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                num5_reg[i] <= 62'({sm_reg[SQ-1][i], {UF{1'b0}}}) + 62'(root_m[31:1]);
            end
            m5_reg   <= root_m;
            neg5_reg <= sneg_reg[SQ-1];
            nz5_reg  <= snz_reg[SQ-1];
        end
    end

    // Restoring division, one quotient bit per stage on all three lanes.
    logic [2:0][31:0] rem_reg  [DV];
    logic [2:0][30:0] low_reg  [DV];
    logic [2:0][30:0] quo_reg  [DV];
    logic [31:0]      dm_reg   [DV];
    logic [2:0]       dneg_reg [DV];
    logic             dnz_reg  [DV];
    logic             dv_reg   [DV];

    for (genvar j = 0; j < DV; j++) begin : g_div
        logic [2:0][31:0] rem_in;
        logic [2:0][30:0] low_in;
        logic [2:0][30:0] quo_in;
        logic [31:0]      m_in;
        logic [2:0]       neg_in;
        logic             nz_in;
        logic             v_in;
        logic [2:0][32:0] trial;
        logic [2:0][32:0] diff;
        logic [2:0]       qbit;

        if (j == 0) begin : g_first
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign rem_in[i] = {1'b0, num5_reg[i][61:31]};
                assign low_in[i] = num5_reg[i][30:0];
                assign quo_in[i] = 31'd0;
            end
            assign m_in   = m5_reg;
            assign neg_in = neg5_reg;
            assign nz_in  = nz5_reg;
            assign v_in   = v5_reg;
        end else begin : g_next
            assign rem_in = rem_reg[j-1];
            assign low_in = low_reg[j-1];
            assign quo_in = quo_reg[j-1];
            assign m_in   = dm_reg[j-1];
            assign neg_in = dneg_reg[j-1];
            assign nz_in  = dnz_reg[j-1];
            assign v_in   = dv_reg[j-1];
        end

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                trial[i] = {rem_in[i], low_in[i][30]};
                diff[i]  = trial[i] - {1'b0, m_in};
                qbit[i]  = (trial[i] >= {1'b0, m_in});
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[j] <= 1'b0;
            end else if (en) begin
                dv_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    rem_reg[j][i] <= qbit[i] ? diff[i][31:0] : trial[i][31:0];
                    low_reg[j][i] <= {low_in[i][29:0], 1'b0};
                    quo_reg[j][i] <= {quo_in[i][29:0], qbit[i]};
                end
                dm_reg[j]   <= m_in;
                dneg_reg[j] <= neg_in;
                dnz_reg[j]  <= nz_in;
            end
        end
    end

    // Final stage: restore signs; a zero vector gives a zero result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (en) begin
            out_valid <= dv_reg[DV-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (!dnz_reg[DV-1]) begin
                    unit_out[i] <= '0;
                end else if (dneg_reg[DV-1][i]) begin
                    unit_out[i] <= -$signed({1'b0, quo_reg[DV-1][i]});
                end else begin
                    unit_out[i] <= $signed({1'b0, quo_reg[DV-1][i]});
                end
            end
            nonzero_out <= dnz_reg[DV-1];
        end
    end

endmodule

[rtl/hfp_mix.sv]
// Cross product with the unit wave vector and helical mixing, four stages.
`timescale 1ns / 1ps
module hfp_mix (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  hfp_pkg::mix_in_t   mix_in,
    output logic               out_valid,
    output hfp_pkg::out_word_t out_data
);
    localparam int UF = hfp_pkg::UNIT_FRAC;

    function automatic hfp_pkg::word_t field_re(input hfp_pkg::side_t s, input int i);
        case (i)
            0:       return s.fx_real;
            1:       return s.fy_real;
            default: return s.fz_real;
        endcase
    endfunction

    function automatic hfp_pkg::word_t field_im(input hfp_pkg::side_t s, input int i);
        case (i)
            0:       return s.fx_imag;
            1:       return s.fy_imag;
            default: return s.fz_imag;
        endcase
    endfunction

    function automatic hfp_pkg::word_t sat_word(input logic signed [37:0] v);
        if (v > 38'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -38'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    hfp_pkg::mix_in_t a_reg;
    hfp_pkg::mix_in_t b_reg;
    hfp_pkg::mix_in_t c_reg;
    logic             va_reg;
    logic             vb_reg;
    logic             vc_reg;
    logic             vd_reg;
    logic             ge_reg;

    logic signed [63:0] pa_r_reg [3];
    logic signed [63:0] pb_r_reg [3];
    logic signed [63:0] pa_i_reg [3];
    logic signed [63:0] pb_i_reg [3];
    logic signed [33:0] cr_reg   [3];
    logic signed [33:0] ci_reg   [3];
    logic signed [63:0] t0r_reg  [3];
    logic signed [63:0] t0i_reg  [3];
    logic signed [65:0] t1r_reg  [3];
    logic signed [65:0] t1i_reg  [3];
    hfp_pkg::word_t     hr_reg   [3];
    hfp_pkg::word_t     hi_reg   [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg  <= mix_in;
            b_reg  <= a_reg;
            c_reg  <= b_reg;
            ge_reg <= c_reg.side.grid_end;
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
        localparam int J = (i + 1) % 3;
        localparam int L = (i + 2) % 3;
        logic signed [64:0] dr;
        logic signed [64:0] di;
        logic signed [67:0] sr;
        logic signed [67:0] si;

        assign dr = pa_r_reg[i] - pb_r_reg[i] + 65'sd536870912;
        assign di = pa_i_reg[i] - pb_i_reg[i] + 65'sd536870912;
        assign sr = t0r_reg[i] - t1r_reg[i] + 68'sd536870912;
        assign si = t0i_reg[i] + t1i_reg[i] + 68'sd536870912;

        always_ff @(posedge aclk) begin
            if (en) begin
                pa_r_reg[i] <= $signed(mix_in.unit[J]) * $signed(field_re(mix_in.side, L));
                pb_r_reg[i] <= $signed(mix_in.unit[L]) * $signed(field_re(mix_in.side, J));
                pa_i_reg[i] <= $signed(mix_in.unit[J]) * $signed(field_im(mix_in.side, L));
                pb_i_reg[i] <= $signed(mix_in.unit[L]) * $signed(field_im(mix_in.side, J));
                cr_reg[i]   <= 34'(dr >>> UF);
                ci_reg[i]   <= 34'(di >>> UF);
                t0r_reg[i]  <= $signed(b_reg.norm) * $signed(field_re(b_reg.side, i));
                t0i_reg[i]  <= $signed(b_reg.norm) * $signed(field_im(b_reg.side, i));
                // The real part takes the imaginary cross term and vice versa.
                t1r_reg[i]  <= $signed(b_reg.alpha_norm) * ci_reg[i];
                t1i_reg[i]  <= $signed(b_reg.alpha_norm) * cr_reg[i];
                if (c_reg.nonzero) begin
                    hr_reg[i] <= sat_word(38'(sr >>> UF));
                    hi_reg[i] <= sat_word(38'(si >>> UF));
                end else begin
                    hr_reg[i] <= '0;
                    hi_reg[i] <= '0;
                end
            end
        end
    end

    assign out_valid             = vd_reg;
    assign out_data.hx_real      = hr_reg[0];
    assign out_data.hx_imag      = hi_reg[0];
    assign out_data.hy_real      = hr_reg[1];
    assign out_data.hy_imag      = hi_reg[1];
    assign out_data.hz_real      = hr_reg[2];
    assign out_data.hz_imag      = hi_reg[2];
    assign out_data.grid_end_out = ge_reg;

endmodule

[rtl/helical_field_projection_core.sv]
// Top level of the helical field projection block.
`timescale 1ns / 1ps
`include "helical_field_projection_core_assert.svh"
// Usage:
// Each word on the s_ channel is one Fourier-space grid point: wave vector k and
// complex field B. The m_ channel returns one word per point, the helical field
// H with saturated Q16.16 parts and a copy of the grid end mark, in input order.
// cfg_wr_en/cfg_wr_data write the helicity alpha; write it only while no word is
// in flight. Both unit vectors, of k and of (1, alpha, 0), are computed per word.
// Throughput is one word per cycle while the skid register is empty. Each word
// passes through 69 stages of unit vector (32 square root steps and 31 divider
// steps), 4 stages of cross product and mixing, and the output register.
// A zero wave vector gives zero field parts.
// When the receiver stalls, the output register holds its word and one more word
// drops into a skid register; the pipeline and s_ready hold only once the skid
// register is full, so s_ready never depends on m_ready in the same cycle.
// Synchronous active-low reset clears all valid bits, the skid valid flag and
// alpha (alpha resets to zero).
module helical_field_projection_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  hfp_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output hfp_pkg::out_word_t m_data,
    input  logic               cfg_wr_en,
    input  hfp_pkg::word_t     cfg_wr_data
);
    localparam int LAT = hfp_pkg::UV_LAT;

    hfp_pkg::word_t     alpha_reg;
    logic               en;
    hfp_pkg::vec3_t     k_vec;
    hfp_pkg::vec3_t     a_vec;
    hfp_pkg::vec3_t     k_unit;
    hfp_pkg::vec3_t     a_unit;
    logic               k_valid;
    logic               a_valid;
    logic               k_nonzero;
    logic               a_nonzero;
    hfp_pkg::side_t     side_reg [LAT];
    hfp_pkg::mix_in_t   mix_in;
    logic               mix_valid;
    hfp_pkg::out_word_t mix_data;
    logic               take;
    logic               out_valid_reg;
    logic               out_valid_next;
    hfp_pkg::out_word_t out_data_reg;
    logic               skid_valid_reg;
    logic               skid_valid_next;
    hfp_pkg::out_word_t skid_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= '0;
        end else if (cfg_wr_en) begin
            alpha_reg <= cfg_wr_data;
        end
    end

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    assign k_vec[0] = s_data.wave_x;
    assign k_vec[1] = s_data.wave_y;
    assign k_vec[2] = s_data.wave_z;
    assign a_vec[0] = hfp_pkg::ONE_Q;
    assign a_vec[1] = alpha_reg;
    assign a_vec[2] = '0;

    hfp_unit_vec u_k_unit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s_valid),
        .vec_in      (k_vec),
        .out_valid   (k_valid),
        .unit_out    (k_unit),
        .nonzero_out (k_nonzero)
    );

    hfp_unit_vec u_a_unit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s_valid),
        .vec_in      (a_vec),
        .out_valid   (a_valid),
        .unit_out    (a_unit),
        .nonzero_out (a_nonzero)
    );

    // The field and end mark wait alongside the unit vector pipeline.
    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0].fx_real  <= s_data.fx_real;
            side_reg[0].fx_imag  <= s_data.fx_imag;
            side_reg[0].fy_real  <= s_data.fy_real;
            side_reg[0].fy_imag  <= s_data.fy_imag;
            side_reg[0].fz_real  <= s_data.fz_real;
            side_reg[0].fz_imag  <= s_data.fz_imag;
            side_reg[0].grid_end <= s_data.grid_end;
            for (int i = 1; i < LAT; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign mix_in.unit       = k_unit;
    assign mix_in.norm       = a_unit[0];
    assign mix_in.alpha_norm = a_unit[1];
    assign mix_in.nonzero    = k_nonzero;
    assign mix_in.side       = side_reg[LAT-1];

    hfp_mix u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (k_valid),
        .mix_in    (mix_in),
        .out_valid (mix_valid),
        .out_data  (mix_data)
    );

    // Output register with one skid word behind it.
    assign take = en && mix_valid;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || m_ready) begin
            out_valid_next  = skid_valid_reg || take;
            skid_valid_next = 1'b0;
        end else if (take) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : mix_data;
        end else if (take) begin
            skid_data_reg <= mix_data;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    `HFP_ASSERT_IMP(a_units_aligned, aclk, aresetn, 1'b1, k_valid == a_valid)
    `HFP_ASSERT_IMP(a_alpha_nonzero, aclk, aresetn, a_valid, a_nonzero)
    `HFP_ASSERT_IMP(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `HFP_ASSERT_NEXT(a_skid_fills, aclk, aresetn, out_valid_reg && !m_ready && take, skid_valid_reg)

endmodule
